[hdl/positional_array_list_macros.svh]
// Assertion macros shared by the checker of the positional array list.
`ifndef POSITIONAL_ARRAY_LIST_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_MACROS_SVH

// Same-cycle implication, sampled on clk_i and idle while rst_ni is low.
`define PAL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("positional_array_list check failed");

// Next-cycle implication, sampled on clk_i and idle while rst_ni is low.
`define PAL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("positional_array_list check failed");

`endif

[hdl/pal_pkg.sv]
// Package with the request kinds, status codes and cell control type of the list.
`timescale 1ns / 1ps
`default_nettype none

package pal_pkg;

  localparam int DataW = 32;
  localparam int PosW  = 8;
  localparam int CntW  = 8;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_READ   = 2'd3
  } pal_kind_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } pal_status_e;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic             shift_up;
    logic             shift_dn;
    logic [DataW-1:0] value;
  } pal_ctrl_t;

endpackage

`default_nettype wire

[hdl/pal_cell.sv]
// One storage cell of the list chain, holding the entry at a fixed index.
`timescale 1ns / 1ps
`default_nettype none

module pal_cell #(
  parameter int IdxW = 7,
  parameter int Idx  = 0
) (
  input  wire logic                    clk_i,
  input  wire pal_pkg::pal_ctrl_t      ctrl_i,
  input  wire logic [IdxW-1:0]         pos_i,
  input  wire logic [pal_pkg::DataW-1:0] prev_i,
  input  wire logic [pal_pkg::DataW-1:0] next_i,
  output logic      [pal_pkg::DataW-1:0] data_o,
  output logic      [pal_pkg::DataW-1:0] rd_o
);
  import pal_pkg::*;

  localparam logic [IdxW-1:0] MyIdx = IdxW'(Idx);

  logic [DataW-1:0] data_q;
  logic [DataW-1:0] data_d;
  logic             above;
  logic             hit;

  assign hit   = (pos_i == MyIdx);
  assign above = (MyIdx > pos_i);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift_up) begin
      if (above) begin
        data_d = prev_i;
      end else if (hit) begin
        data_d = ctrl_i.value;
      end
    end else if (ctrl_i.shift_dn) begin
      if (above || hit) begin
        data_d = next_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // Only the addressed cell drives its entry onto the read bus.
  assign rd_o   = data_q & {DataW{hit}};

endmodule

`default_nettype wire

[hdl/positional_array_list.sv]
// Top level of the positional array list: request decode, count and a chain of entry cells.
//
//   channel  | direction | content
//   s_axis   | in        | tuser = kind, tdata = position, value
//   m_axis   | out       | tdata = data, status, count, empty_res, full_res
//
// A request transaction updates the whole cell chain in the clock cycle in which it is
// accepted, so the list takes one transaction per cycle unless m_axis stalls; its result is registered and
// shows on m_axis in the following cycle.
// The output register is the only stage: s_axis_tready is low only while a result waits
// on a stalled m_axis, so a stall on the result side holds off the next request.
// Reset clears the entry count and the output valid; the cells keep whatever they held,
// which is never read because reads only reach positions below the count.
`timescale 1ns / 1ps
`default_nettype none

module positional_array_list #(
  parameter int CAPACITY = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [1:0]  s_axis_tuser,   // kind [1:0]
  input  wire logic [39:0] s_axis_tdata,   // position [7:0], value [39:8]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata    // data [31:0], status [33:32], count [41:34],
                                           // empty_res [42], full_res [43], zeros above
);
  import pal_pkg::*;

  // Count holds 0..CAPACITY; a cell index holds 0..CAPACITY-1.
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = $clog2(CAPACITY);
  localparam int CmpW = (CW > PosW) ? CW : PosW;
  localparam logic [CW-1:0] CapVal = CW'(CAPACITY);

  // Request fields.
  pal_kind_e        kind;
  logic [PosW-1:0]  pos;
  logic [DataW-1:0] value;
  logic [CmpW-1:0]  pos_ext;
  logic [CmpW-1:0]  cnt_ext;

  logic             accept;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             full_now;

  // Decoded operation.
  pal_ctrl_t        ctrl;
  logic [IW-1:0]    cell_pos;
  pal_status_e      status;
  logic             want_rd;
  logic             do_ins, do_del;

  // Cell chain.
  logic [DataW-1:0] cell_data [CAPACITY];
  logic [DataW-1:0] cell_rd   [CAPACITY];
  logic [DataW-1:0] rd_data;

  // Result register.
  logic             out_valid_q;
  logic [DataW-1:0] res_data_q, res_data_d;
  pal_status_e      res_status_q;
  logic [CntW-1:0]  res_count_q;
  logic             res_empty_q, res_full_q;

  assign kind    = pal_kind_e'(s_axis_tuser);
  assign pos     = s_axis_tdata[PosW-1:0];
  assign value   = s_axis_tdata[PosW +: DataW];
  assign pos_ext = CmpW'(pos);
  assign cnt_ext = CmpW'(cnt_q);

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full_now      = (cnt_q == CapVal);

  // Request decode: range and capacity checks pick the status; a failed request
  // leaves the chain and the count alone.
  always_comb begin
    status   = ST_DONE;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    want_rd  = 1'b0;
    cell_pos = IW'(pos_ext);
    unique case (kind)
      KIND_INSERT: begin
        if (full_now) begin
          status = ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          status = ST_RANGE;
        end else begin
          do_ins = 1'b1;
        end
      end
      KIND_APPEND: begin
        cell_pos = IW'(cnt_q);
        if (full_now) begin
          status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      KIND_DELETE: begin
        if (pos_ext >= cnt_ext) begin
          status = ST_RANGE;
        end else begin
          do_del  = 1'b1;
          want_rd = 1'b1;
        end
      end
      KIND_READ: begin
        if (pos_ext >= cnt_ext) begin
          status = ST_RANGE;
        end else begin
          want_rd = 1'b1;
        end
      end
      default: begin
        status = ST_RANGE;
      end
    endcase
  end

  assign ctrl.shift_up = accept && do_ins;
  assign ctrl.shift_dn = accept && do_del;
  assign ctrl.value    = value;

  // On insert, cells above the position take their lower neighbor and the cell at it the value;
  // on delete, cells at or above it take the upper one. End cells see their own entry in place of a missing neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DataW-1:0] prev_w, next_w;
    if (i == 0) begin : g_first
      assign prev_w = cell_data[i];
    end else begin : g_prev
      assign prev_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_w = cell_data[i];
    end else begin : g_next
      assign next_w = cell_data[i+1];
    end
    pal_cell #(
      .IdxW (IW),
      .Idx  (i)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .pos_i  (cell_pos),
      .prev_i (prev_w),
      .next_i (next_w),
      .data_o (cell_data[i]),
      .rd_o   (cell_rd[i])
    );
  end

  // At most one cell drives a nonzero word, so an OR gathers the addressed entry.
  always_comb begin
    rd_data = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_data = rd_data | cell_rd[k];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (do_ins) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_del) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  assign res_data_d = want_rd ? rd_data : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q <= cnt_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_data_q   <= res_data_d;
      res_status_q <= status;
      res_count_q  <= CntW'(cnt_d);
      res_empty_q  <= (cnt_d == '0);
      res_full_q   <= (cnt_d == CapVal);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, res_full_q, res_empty_q, res_count_q,
                          res_status_q, res_data_q};

endmodule

`default_nettype wire

[hdl/pal_checker.sv]
// Port-level checker for the positional array list, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
`include "positional_array_list_macros.svh"

module pal_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata
);
  import pal_pkg::*;

  logic err_res;

  // An offered result whose status reports a failed request.
  assign err_res = m_axis_tvalid && (m_axis_tdata[33:32] != ST_DONE);

  // A held result stays offered until taken.
  `PAL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // Every accepted request leaves a result on the output in the next cycle.
  `PAL_ASSERT_NEXT(a_result_follows, s_axis_tvalid && s_axis_tready, m_axis_tvalid)

  // No request is taken while a finished result is stalled.
  `PAL_ASSERT_NOW(a_no_overrun, m_axis_tvalid && !m_axis_tready, !s_axis_tready)

  // A failed request returns zero data.
  `PAL_ASSERT_NOW(a_err_zero, err_res, m_axis_tdata[31:0] == 32'd0)

endmodule

bind positional_array_list pal_checker u_pal_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
